@@ sv/pil_pkg.sv @@
package pil_pkg;

	localparam int POS_W = 5;
	localparam int VAL_W = 32;
	localparam int LEN_W = 5;
	localparam int STAT_W = 2;
	localparam int CMD_W = 2;
	localparam int S_DATA_W = 40;
	localparam int M_DATA_W = 40;

	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK = 2'd0;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

	// Broadcast from the controller to every cell of the row.
	typedef struct packed {
		logic load_en;
		logic ins;
		logic [POS_W-1:0] pos;
		logic [VAL_W-1:0] value;
	} cell_ctrl_t;

endpackage

@@ sv/pil_cell.sv @@
module pil_cell #(
	parameter int IDX = 0
) (
	input  logic clk,
	input  pil_pkg::cell_ctrl_t ctrl,
	input  logic [pil_pkg::VAL_W-1:0] left_data,
	input  logic [pil_pkg::VAL_W-1:0] right_data,
	output logic [pil_pkg::VAL_W-1:0] data
);

	localparam int IW = (IDX < 32) ? pil_pkg::POS_W : $clog2(IDX + 1);

	logic [pil_pkg::VAL_W-1:0] data_q;
	logic above_pos;
	logic at_pos;

	assign at_pos = (IW'(ctrl.pos) == IW'(IDX));
	assign above_pos = (IW'(IDX) > IW'(ctrl.pos));

	// An insert shifts cells above the position up and loads the new value at it;
	// a delete pulls every cell from the position upward down by one.
	always_ff @(posedge clk) begin
		if (ctrl.load_en) begin
			if (ctrl.ins) begin
				if (above_pos) begin
					data_q <= left_data;
				end else if (at_pos) begin
					data_q <= ctrl.value;
				end
			end else if (above_pos || at_pos) begin
				data_q <= right_data;
			end
		end
	end

	assign data = data_q;

endmodule

@@ sv/positional_integer_list.sv @@
// Channel  Dir  Bits  Contents
// s_*      in   40    tdata: pos[4:0], value_in[36:5], zero fill; tuser: cmd[1:0]
// m_*      out  40    tdata: value_out[31:0], length[36:32], is_empty[37], status[39:38]
//
// Every request is decided and applied to the row of cells
// at the edge that accepts it, and its result word appears in the output
// register the cycle after. A new word is accepted in every cycle in which the
// output register is empty or being taken, so the rate is one word per cycle.
// Reset empties the list; the cell storage is not cleared.
// A stall on m_tready holds the result and drops s_tready.
module positional_integer_list #(
	parameter int CAPACITY = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [pil_pkg::S_DATA_W-1:0] s_tdata, // pos, value_in, zero fill
	input  logic [pil_pkg::CMD_W-1:0] s_tuser,    // cmd
	output logic m_tvalid,
	input  logic m_tready,
	output logic [pil_pkg::M_DATA_W-1:0] m_tdata  // value_out, length, is_empty, status
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = ((CW > pil_pkg::POS_W) ? CW : pil_pkg::POS_W) + 1;

	logic [CW-1:0] count_q;
	logic [CW-1:0] count_d;
	logic out_valid_q;
	logic [pil_pkg::VAL_W-1:0] value_out_q;
	logic [pil_pkg::LEN_W-1:0] length_q;
	logic is_empty_q;
	logic [pil_pkg::STAT_W-1:0] status_q;

	logic accept;
	logic [pil_pkg::CMD_W-1:0] cmd;
	logic [pil_pkg::POS_W-1:0] pos;
	logic [pil_pkg::VAL_W-1:0] value_in;
	logic [XW-1:0] pos_x;
	logic [XW-1:0] count_x;
	logic change;
	logic [pil_pkg::STAT_W-1:0] status_d;
	logic [pil_pkg::VAL_W-1:0] read_sel;
	logic [pil_pkg::VAL_W-1:0] read_d;
	pil_pkg::cell_ctrl_t ctrl;
	logic [pil_pkg::VAL_W-1:0] cell_data [CAPACITY];

	assign cmd = s_tuser;
	assign pos = s_tdata[pil_pkg::POS_W-1:0];
	assign value_in = s_tdata[pil_pkg::POS_W +: pil_pkg::VAL_W];
	assign pos_x = XW'(pos);
	assign count_x = XW'(count_q);

	assign s_tready = !out_valid_q || m_tready;
	assign accept = s_tvalid && s_tready;

	always_comb begin
		read_sel = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (pos_x == XW'(i)) begin
				read_sel = read_sel | cell_data[i];
			end
		end
	end

	always_comb begin
		change = 1'b0;
		status_d = pil_pkg::ST_OK;
		read_d = '0;
		count_d = count_q;
		case (cmd)
			pil_pkg::CMD_INSERT: begin
				if (pos_x > count_x) begin
					status_d = pil_pkg::ST_RANGE;
				end else if (count_x >= XW'(CAPACITY)) begin
					status_d = pil_pkg::ST_FULL;
				end else begin
					change = 1'b1;
					count_d = count_q + CW'(1);
				end
			end
			pil_pkg::CMD_DELETE: begin
				if (pos_x >= count_x) begin
					status_d = pil_pkg::ST_RANGE;
				end else begin
					change = 1'b1;
					count_d = count_q - CW'(1);
				end
			end
			pil_pkg::CMD_READ: begin
				if (pos_x >= count_x || pos_x >= XW'(CAPACITY)) begin
					status_d = pil_pkg::ST_RANGE;
				end else begin
					read_d = read_sel;
				end
			end
			default: begin
				status_d = pil_pkg::ST_RANGE;
			end
		endcase
	end

	assign ctrl.load_en = accept && change;
	assign ctrl.ins = (cmd == pil_pkg::CMD_INSERT);
	assign ctrl.pos = pos;
	assign ctrl.value = value_in;

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		pil_cell #(
			.IDX(g)
		) u_cell (
			.clk(clk),
			.ctrl(ctrl),
			.left_data((g == 0) ? value_in : cell_data[(g == 0) ? 0 : g - 1]),
			.right_data(cell_data[(g == CAPACITY - 1) ? g : g + 1]),
			.data(cell_data[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_d;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			value_out_q <= read_d;
			length_q <= pil_pkg::LEN_W'(count_d);
			is_empty_q <= (count_d == '0);
			status_q <= status_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {status_q, is_empty_q, length_q, value_out_q};

endmodule

@@ sv/pil_checker.sv @@
module pil_checker (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic [pil_pkg::CMD_W-1:0] s_tuser,
	input logic m_tvalid,
	input logic m_tready,
	input logic [pil_pkg::M_DATA_W-1:0] m_tdata
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	a_empty_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[37] |-> m_tdata[36:32] == 5'd0)
		else $error("empty list reports a nonzero length");

	a_value_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[31:0] != 32'd0 |-> m_tdata[39:38] == pil_pkg::ST_OK)
		else $error("nonzero value with an error status");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[39:38] == pil_pkg::ST_OK || m_tdata[39:38] == pil_pkg::ST_RANGE
			|| m_tdata[39:38] == pil_pkg::ST_FULL)
		else $error("undefined status code");

	a_bad_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser != pil_pkg::CMD_INSERT
			&& s_tuser != pil_pkg::CMD_DELETE && s_tuser != pil_pkg::CMD_READ
		|=> m_tvalid && m_tdata[39:38] == pil_pkg::ST_RANGE && m_tdata[31:0] == 32'd0)
		else $error("unknown command not rejected");

endmodule

bind positional_integer_list pil_checker u_pil_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tuser(s_tuser),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata)
);

@@ tb/sv/tb_top.sv @@
module tb_top;

	localparam int LIST_CAP = 16;
	localparam int RANDOM_WORDS = 1500;
	localparam int IDLE_LIMIT = 3000;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam logic [pil_pkg::CMD_W-1:0] CMD_UNKNOWN = 2'd3;

	// Packed to match m_tdata, lowest field last.
	typedef struct packed {
		logic [pil_pkg::STAT_W-1:0] status;
		logic is_empty;
		logic [pil_pkg::LEN_W-1:0] length;
		logic [pil_pkg::VAL_W-1:0] value_out;
	} list_result_t;

	typedef struct {
		logic [pil_pkg::CMD_W-1:0] cmd;
		logic [pil_pkg::POS_W-1:0] pos;
		logic [pil_pkg::VAL_W-1:0] value;
		bit fixed;
		list_result_t want;
	} request_row_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [pil_pkg::S_DATA_W-1:0] s_tdata;  // pos, value_in, zero fill
	logic [pil_pkg::CMD_W-1:0] s_tuser;     // cmd
	logic m_tvalid;
	logic m_tready;
	logic [pil_pkg::M_DATA_W-1:0] m_tdata;  // value_out, length, is_empty, status

	logic [pil_pkg::VAL_W-1:0] list_mem [LIST_CAP];
	int list_len;
	list_result_t pending_results[$];
	request_row_t directed_rows[$];
	int error_count;
	int words_sent;
	int results_seen;
	int full_seen;
	int empty_seen;
	int idle_cycles;

	positional_integer_list #(
		.CAPACITY(LIST_CAP)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic list_result_t make_result(logic [pil_pkg::VAL_W-1:0] v, int len,
			logic [pil_pkg::STAT_W-1:0] st);
		list_result_t r;
		r.value_out = v;
		r.length = len[pil_pkg::LEN_W-1:0];
		r.is_empty = (len == 0);
		r.status = st;
		return r;
	endfunction

	// Applies one request to the shadow list and returns the word it produces.
	function automatic list_result_t apply_request(logic [pil_pkg::CMD_W-1:0] cmd,
			logic [pil_pkg::POS_W-1:0] pos, logic [pil_pkg::VAL_W-1:0] val);
		list_result_t r;
		int p;
		int i;
		p = int'(pos);
		r.value_out = '0;
		r.status = pil_pkg::ST_OK;
		case (cmd)
			pil_pkg::CMD_INSERT: begin
				if (p > list_len) begin
					r.status = pil_pkg::ST_RANGE;
				end else if (list_len >= LIST_CAP) begin
					r.status = pil_pkg::ST_FULL;
				end else begin
					for (i = list_len; i > p; i--)
						list_mem[i] = list_mem[i-1];
					list_mem[p] = val;
					list_len++;
				end
			end
			pil_pkg::CMD_DELETE: begin
				if (p >= list_len) begin
					r.status = pil_pkg::ST_RANGE;
				end else begin
					for (i = p; i + 1 < list_len; i++)
						list_mem[i] = list_mem[i+1];
					list_len--;
				end
			end
			pil_pkg::CMD_READ: begin
				if (p >= list_len)
					r.status = pil_pkg::ST_RANGE;
				else
					r.value_out = list_mem[p];
			end
			default: begin
				r.status = pil_pkg::ST_RANGE;
			end
		endcase
		r.length = list_len[pil_pkg::LEN_W-1:0];
		r.is_empty = (list_len == 0);
		return r;
	endfunction

	task automatic add_row(logic [pil_pkg::CMD_W-1:0] cmd, int pos,
			logic [pil_pkg::VAL_W-1:0] val, bit fixed, list_result_t want);
		request_row_t row;
		row.cmd = cmd;
		row.pos = pos[pil_pkg::POS_W-1:0];
		row.value = val;
		row.fixed = fixed;
		row.want = want;
		directed_rows.push_back(row);
	endtask

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_word(logic [pil_pkg::CMD_W-1:0] cmd, logic [pil_pkg::POS_W-1:0] pos,
			logic [pil_pkg::VAL_W-1:0] val, bit fixed, list_result_t want);
		list_result_t predicted;
		s_tvalid = 1'b1;
		s_tuser = cmd;
		s_tdata = {3'b000, val, pos};
		do
			@(posedge clk);
		while (!s_tready);
		predicted = apply_request(cmd, pos, val);
		pending_results.push_back(fixed ? want : predicted);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic sender_gap();
		int k;
		int gap;
		k = $urandom_range(0, 99);
		if (k < 60)
			gap = 0;
		else if (k < 92)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(10, 50);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	function automatic logic [pil_pkg::VAL_W-1:0] pick_value();
		case ($urandom_range(0, 19))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// Receiver: random stalls, runs of steady acceptance, and one long hold-off.
	initial begin
		int k;
		bit held;
		held = 1'b0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && results_seen >= 300) begin
				held = 1'b1;
				m_tready = 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
			end
			k = $urandom_range(0, 9);
			if (k < 3) begin
				m_tready = 1'b1;
				repeat ($urandom_range(1, 40)) @(negedge clk);
			end else if (k < 9) begin
				m_tready = 1'b0;
				repeat ($urandom_range(1, 3)) @(negedge clk);
				m_tready = 1'b1;
				repeat ($urandom_range(1, 4)) @(negedge clk);
			end else begin
				m_tready = 1'b0;
				repeat ($urandom_range(20, 80)) @(negedge clk);
			end
		end
	end

	always @(posedge clk) begin
		list_result_t got;
		list_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = list_result_t'(m_tdata);
			results_seen++;
			if (got.length == LIST_CAP[pil_pkg::LEN_W-1:0])
				full_seen++;
			if (got.is_empty)
				empty_seen++;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result word %h", $time, m_tdata);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (got.value_out !== want.value_out) begin
					$display("%0t: value_out expected %h actual %h", $time,
						want.value_out, got.value_out);
					error_count++;
				end
				if (got.length !== want.length) begin
					$display("%0t: length expected %0d actual %0d", $time,
						want.length, got.length);
					error_count++;
				end
				if (got.is_empty !== want.is_empty) begin
					$display("%0t: is_empty expected %b actual %b", $time,
						want.is_empty, got.is_empty);
					error_count++;
				end
				if (got.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $time,
						want.status, got.status);
					error_count++;
				end
			end
		end
	end

	// Ends the run if neither side moves a word for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		list_result_t none;
		int j;
		int n;
		int k;
		logic [pil_pkg::CMD_W-1:0] cmd;
		logic [pil_pkg::POS_W-1:0] pos;
		bit filling;

		none = '0;
		error_count = 0;
		words_sent = 0;
		results_seen = 0;
		full_seen = 0;
		empty_seen = 0;
		idle_cycles = 0;
		list_len = 0;
		filling = 1'b1;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = pil_pkg::CMD_INSERT;

		add_row(pil_pkg::CMD_READ, 0, 32'h0, 1'b1,
			make_result(32'h0, 0, pil_pkg::ST_RANGE));
		add_row(pil_pkg::CMD_DELETE, 0, 32'h0, 1'b1,
			make_result(32'h0, 0, pil_pkg::ST_RANGE));
		add_row(pil_pkg::CMD_INSERT, 1, 32'h5, 1'b1,
			make_result(32'h0, 0, pil_pkg::ST_RANGE));
		add_row(pil_pkg::CMD_INSERT, 0, 32'h7fff_ffff, 1'b1,
			make_result(32'h0, 1, pil_pkg::ST_OK));
		add_row(pil_pkg::CMD_INSERT, 0, 32'h8000_0000, 1'b1,
			make_result(32'h0, 2, pil_pkg::ST_OK));
		add_row(pil_pkg::CMD_READ, 0, 32'h0, 1'b1,
			make_result(32'h8000_0000, 2, pil_pkg::ST_OK));
		add_row(pil_pkg::CMD_READ, 1, 32'h0, 1'b1,
			make_result(32'h7fff_ffff, 2, pil_pkg::ST_OK));
		add_row(pil_pkg::CMD_INSERT, 31, 32'h1, 1'b1,
			make_result(32'h0, 2, pil_pkg::ST_RANGE));
		add_row(CMD_UNKNOWN, 0, 32'hffff_ffff, 1'b1,
			make_result(32'h0, 2, pil_pkg::ST_RANGE));
		// Fill to capacity at scattered positions, then probe the full list.
		for (j = 0; j < LIST_CAP - 2; j++)
			add_row(pil_pkg::CMD_INSERT, (j * 3) % (j + 3), $urandom, 1'b0, none);
		add_row(pil_pkg::CMD_INSERT, 16, 32'h2, 1'b1,
			make_result(32'h0, 16, pil_pkg::ST_FULL));
		add_row(pil_pkg::CMD_INSERT, 0, 32'h3, 1'b1,
			make_result(32'h0, 16, pil_pkg::ST_FULL));
		add_row(pil_pkg::CMD_READ, 16, 32'h0, 1'b1,
			make_result(32'h0, 16, pil_pkg::ST_RANGE));
		add_row(pil_pkg::CMD_READ, 15, 32'h0, 1'b0, none);
		add_row(pil_pkg::CMD_DELETE, 0, 32'h0, 1'b0, none);

		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			send_word(directed_rows[i].cmd, directed_rows[i].pos, directed_rows[i].value,
				directed_rows[i].fixed, directed_rows[i].want);
			sender_gap();
		end

		// Random part: mostly valid positions, swinging between filling and
		// draining so both the full and the empty list are reached often.
		for (n = 0; n < RANDOM_WORDS; n++) begin
			if (n == 800) begin
				s_tvalid = 1'b0;
				while (pending_results.size() != 0)
					@(negedge clk);
			end
			if (list_len >= LIST_CAP)
				filling = 1'b0;
			else if (list_len == 0)
				filling = 1'b1;
			else if ($urandom_range(0, 49) == 0)
				filling = ~filling;
			k = $urandom_range(0, 99);
			if (k < 4) begin
				cmd = pil_pkg::CMD_W'($urandom_range(0, 3));
				pos = pil_pkg::POS_W'($urandom_range(0, 31));
			end else begin
				k = $urandom_range(0, 99);
				if (k < (filling ? 60 : 25))
					cmd = pil_pkg::CMD_INSERT;
				else if (k < 80)
					cmd = pil_pkg::CMD_DELETE;
				else
					cmd = pil_pkg::CMD_READ;
				if ($urandom_range(0, 9) == 0)
					pos = pil_pkg::POS_W'($urandom_range(list_len, 31));
				else if (cmd == pil_pkg::CMD_INSERT || list_len == 0)
					pos = pil_pkg::POS_W'($urandom_range(0, list_len));
				else
					pos = pil_pkg::POS_W'($urandom_range(0, list_len - 1));
			end
			send_word(cmd, pos, pick_value(), 1'b0, none);
			sender_gap();
		end

		s_tvalid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		$display("Sent %0d request words, checked %0d results.", words_sent, results_seen);
		$display("Results showed a full list %0d times and an empty list %0d times.",
			full_seen, empty_seen);
		if (error_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
